@@ hdl/cff_dict_token_decoder_defines.svh @@
// Assertion macros for the DICT token decoder checker.
`ifndef CFF_DICT_TOKEN_DECODER_DEFINES_SVH
`define CFF_DICT_TOKEN_DECODER_DEFINES_SVH

// Check that cons holds in the cycle where ante holds.
`define CFFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define CFFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cffd_pkg.sv @@
// Shared types and token codes for the DICT token decoder.
`default_nettype none

package cffd_pkg;

  typedef enum logic [3:0] {
    KIND_OP      = 4'd0,
    KIND_ESCOP   = 4'd1,
    KIND_ESCUNK  = 4'd2,
    KIND_INT     = 4'd3,
    KIND_NIBBLE  = 4'd4,
    KIND_REALEND = 4'd5,
    KIND_RESV    = 4'd6,
    KIND_UNSUP   = 4'd7,
    KIND_TRUNC   = 4'd8
  } token_kind_e;

  typedef struct packed {
    logic [7:0] dict_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    token_kind_e        token_kind;
    logic [7:0]         operator_code;
    logic signed [31:0] int_value;
    logic [3:0]         real_nibble;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } dec_res_t;

  localparam out_word_t BLANK_WORD = '{
    token_kind:    KIND_OP,
    operator_code: 8'd0,
    int_value:     32'sd0,
    real_nibble:   4'd0,
    last:          1'b0
  };

endpackage

`default_nettype wire

@@ hdl/cff_dict_token_decoder.sv @@
// Top level of the DICT byte-stream token decoder.
//
//   channel  direction  handshake             word
//   in       input      in_valid_i/in_stall_o    dict_byte, stream_end
//   out      output     out_valid_o/out_stall_i  token_kind, operator_code,
//                                                int_value, real_nibble, last
//
// One byte is taken per cycle while in_stall_o is low; its tokens enter a
// four-word result queue in the same cycle and leave it one word per cycle
// while out_stall_i is low, so bytes giving two real nibbles are paced by the
// single output port. Each word is registered in the queue and read from its head.
// Reset clears the decode phase and empties the queue.
// in_stall_o rises while the queue has fewer than two free words.
`default_nettype none

module cff_dict_token_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cffd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cffd_pkg::out_word_t out_word_o
);

  logic               step;
  logic               full;
  cffd_pkg::dec_res_t res;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  cffd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_word_i),
    .res_o  (res)
  );

  cffd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

@@ hdl/cffd_decode.sv @@
// Byte decoder: phase state and per-byte token generation.
`default_nettype none

module cffd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cffd_pkg::in_word_t word_i,
  output cffd_pkg::dec_res_t res_o
);

  localparam logic [7:0]  EscByte   = 8'd12;
  localparam logic [7:0]  LastOp    = 8'd27;
  localparam logic [7:0]  Int16Lead = 8'd28;
  localparam logic [7:0]  Int32Lead = 8'd29;
  localparam logic [7:0]  RealLead  = 8'd30;
  localparam logic [7:0]  Type2Lead = 8'd31;
  localparam logic [7:0]  LastShort = 8'd246;
  localparam logic [7:0]  PosLead   = 8'd247;
  localparam logic [7:0]  PosLast   = 8'd250;
  localparam logic [7:0]  NegLast   = 8'd254;
  localparam logic [7:0]  MaxEscOp  = 8'd39;
  localparam logic [31:0] ShortBias = 32'd139;
  localparam logic [31:0] LongBias  = 32'd108;
  localparam logic [3:0]  NibEnd    = 4'hf;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_INT  = 4'b0100,
    PH_REAL = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  lead_q, lead_d;

  logic [7:0]  b;
  logic [3:0]  hi, lo;
  logic [31:0] acc_shift;
  logic [2:0]  left_dec;
  logic [7:0]  lead_off;
  logic [1:0]  neg_k;
  logic [31:0] pos_val, neg_mag, int_fin;
  cffd_pkg::out_word_t r0, r1;
  logic [1:0]  cnt;

  assign b         = word_i.dict_byte;
  assign hi        = b[7:4];
  assign lo        = b[3:0];
  assign acc_shift = {acc_q[23:0], b};
  assign left_dec  = left_q - 3'd1;
  assign lead_off  = lead_q - PosLead;
  assign neg_k     = lead_q[1:0] + 2'd1;
  assign pos_val   = LongBias + {22'd0, lead_off[1:0], b};
  assign neg_mag   = LongBias + {22'd0, neg_k, b};

  always_comb begin
    if (lead_q == Int16Lead) begin
      int_fin = {{16{acc_shift[15]}}, acc_shift[15:0]};
    end else if (lead_q == Int32Lead) begin
      int_fin = acc_shift;
    end else if (lead_q >= PosLead && lead_q <= PosLast) begin
      int_fin = pos_val;
    end else begin
      int_fin = 32'd0 - neg_mag;
    end
  end

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    acc_d   = acc_q;
    lead_d  = lead_q;
    cnt     = 2'd0;
    r0      = cffd_pkg::BLANK_WORD;
    r1      = cffd_pkg::BLANK_WORD;
    case (phase_q)
      PH_ESC: begin
        r0.token_kind    = (b > MaxEscOp) ? cffd_pkg::KIND_ESCUNK : cffd_pkg::KIND_ESCOP;
        r0.operator_code = b;
        cnt              = 2'd1;
        phase_d          = PH_IDLE;
      end
      PH_INT: begin
        acc_d  = acc_shift;
        left_d = left_dec;
        if (left_dec == 3'd0) begin
          r0.token_kind = cffd_pkg::KIND_INT;
          r0.int_value  = int_fin;
          cnt           = 2'd1;
          phase_d       = PH_IDLE;
        end
      end
      PH_REAL: begin
        if (hi == NibEnd) begin
          r0.token_kind = cffd_pkg::KIND_REALEND;
          cnt           = 2'd1;
          phase_d       = PH_IDLE;
        end else begin
          r0.token_kind  = cffd_pkg::KIND_NIBBLE;
          r0.real_nibble = hi;
          cnt            = 2'd2;
          if (lo == NibEnd) begin
            r1.token_kind = cffd_pkg::KIND_REALEND;
            phase_d       = PH_IDLE;
          end else begin
            r1.token_kind  = cffd_pkg::KIND_NIBBLE;
            r1.real_nibble = lo;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (b == EscByte) begin
          phase_d = PH_ESC;
        end else if (b <= LastOp) begin
          r0.token_kind    = cffd_pkg::KIND_OP;
          r0.operator_code = b;
          cnt              = 2'd1;
        end else if (b == Int16Lead || b == Int32Lead) begin
          lead_d  = b;
          acc_d   = 32'd0;
          left_d  = (b == Int16Lead) ? 3'd2 : 3'd4;
          phase_d = PH_INT;
        end else if (b == RealLead) begin
          phase_d = PH_REAL;
        end else if (b == Type2Lead) begin
          r0.token_kind = cffd_pkg::KIND_UNSUP;
          cnt           = 2'd1;
        end else if (b <= LastShort) begin
          r0.token_kind = cffd_pkg::KIND_INT;
          r0.int_value  = {24'd0, b} - ShortBias;
          cnt           = 2'd1;
        end else if (b <= NegLast) begin
          lead_d  = b;
          acc_d   = 32'd0;
          left_d  = 3'd1;
          phase_d = PH_INT;
        end else begin
          r0.token_kind = cffd_pkg::KIND_RESV;
          cnt           = 2'd1;
        end
      end
    endcase
    if (word_i.stream_end && phase_d != PH_IDLE) begin
      r0            = cffd_pkg::BLANK_WORD;
      r1            = cffd_pkg::BLANK_WORD;
      r0.token_kind = cffd_pkg::KIND_TRUNC;
      cnt           = 2'd1;
      phase_d       = PH_IDLE;
      left_d        = 3'd0;
      acc_d         = 32'd0;
      lead_d        = 8'd0;
    end
    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end
    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 3'd0;
      acc_q   <= 32'd0;
      lead_q  <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      lead_q  <= lead_d;
    end
  end

  assign res_o.count  = cnt;
  assign res_o.first  = r0;
  assign res_o.second = r1;

endmodule

`default_nettype wire

@@ hdl/cffd_result_fifo.sv @@
// Result queue: takes up to two tokens a cycle, hands out one while out_stall_i is low.
`default_nettype none

module cffd_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cffd_pkg::dec_res_t  res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cffd_pkg::out_word_t out_word_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cffd_pkg::out_word_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CntW-1:0] count_q, count_d, push_n;
  logic            pop;

  assign push_n   = push_i ? CntW'(res_i.count) : '0;
  assign pop      = out_valid_o && !out_stall_i;
  assign wr_next  = wr_ptr_q + PtrW'(1);
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_n);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + push_n - CntW'(pop);

  assign full_o      = count_q > CntW'(Depth - 2);
  assign out_valid_o = count_q != '0;
  assign out_word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != '0) begin
      mem_q[wr_ptr_q] <= res_i.first;
    end
    if (push_n == CntW'(2)) begin
      mem_q[wr_next] <= res_i.second;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cffd_checker.sv @@
// Port checker for the DICT token decoder, bound to the top level.
`default_nettype none
`include "cff_dict_token_decoder_defines.svh"

module cffd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cffd_pkg::out_word_t out_word_o
);

  `CFFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "out word dropped while stalled")
  `CFFD_ASSERT_NOW(a_kind_range, out_valid_o, out_word_o.token_kind <= cffd_pkg::KIND_TRUNC, "bad token kind")
  `CFFD_ASSERT_NOW(a_trunc_last, out_valid_o && out_word_o.token_kind == cffd_pkg::KIND_TRUNC, out_word_o.last, "truncated token not last")
  `CFFD_ASSERT_NOW(a_rend_last, out_valid_o && out_word_o.token_kind == cffd_pkg::KIND_REALEND, out_word_o.last, "real end not last")

endmodule

bind cff_dict_token_decoder cffd_checker u_cffd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking bench for the DICT token decoder: directed and random byte streams against a token predictor.
`default_nettype none

module testbench;
  import cffd_pkg::*;

  localparam logic [7:0] BYTE_ESC     = 8'd12;
  localparam logic [7:0] BYTE_SHORT   = 8'd28;
  localparam logic [7:0] BYTE_LONG    = 8'd29;
  localparam logic [7:0] BYTE_REAL    = 8'd30;
  localparam logic [7:0] BYTE_T2      = 8'd31;
  localparam logic [7:0] BYTE_RSVD    = 8'd255;
  localparam logic [7:0] LAST_OP      = 8'd27;
  localparam logic [7:0] LAST_ESCOP   = 8'd39;
  localparam logic [7:0] FIRST_SMALL  = 8'd32;
  localparam logic [7:0] LAST_SMALL   = 8'd246;
  localparam logic [7:0] FIRST_POS2   = 8'd247;
  localparam logic [7:0] LAST_POS2    = 8'd250;
  localparam logic [7:0] FIRST_NEG2   = 8'd251;
  localparam logic [7:0] LAST_NEG2    = 8'd254;
  localparam logic [3:0] NIB_END      = 4'hf;

  localparam int STREAM_BYTES   = 1830;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 16;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ESCAPE  = 4'd1,
    PH_INTEGER = 4'd2,
    PH_REAL    = 4'd3
  } phase_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  phase_e      dec_phase = PH_IDLE;
  logic [2:0]  ints_left = '0;
  logic [31:0] acc       = '0;
  logic [7:0]  lead      = '0;

  in_word_t  pending [$];
  out_word_t expected_tokens [$];
  out_word_t want;

  int bytes_in     = 0;
  int mismatches   = 0;
  int idle_cycles  = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  int hold_left    = 0;
  int next_hold_at = 400;
  bit in_taken     = 1'b0;
  bit out_taken;

  cff_dict_token_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit calm_stretch();
    return (bytes_in / 200) % 3 == 1;
  endfunction

  function automatic int gap_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void decode_dict_byte(input in_word_t w);
    out_word_t   tk [2];
    logic [7:0]  b;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [31:0] v;
    int          n;
    b = w.dict_byte;
    hi = b[7:4];
    lo = b[3:0];
    n = 0;
    tk[0] = BLANK_WORD;
    tk[1] = BLANK_WORD;
    case (dec_phase)
      PH_ESCAPE: begin
        tk[0].token_kind = (b > LAST_ESCOP) ? KIND_ESCUNK : KIND_ESCOP;
        tk[0].operator_code = b;
        n = 1;
        dec_phase = PH_IDLE;
      end
      PH_INTEGER: begin
        acc = {acc[23:0], b};
        ints_left = ints_left - 3'd1;
        if (ints_left == 3'd0) begin
          if (lead == BYTE_SHORT) v = {{16{acc[15]}}, acc[15:0]};
          else if (lead == BYTE_LONG) v = acc;
          else if (lead <= LAST_POS2) v = 108 + 256 * (int'(lead) - 247) + int'(b);
          else v = -(108 + 256 * ((int'(lead) - 251) & 3) + int'(b));
          tk[0].token_kind = KIND_INT;
          tk[0].int_value = v;
          n = 1;
          dec_phase = PH_IDLE;
        end
      end
      PH_REAL: begin
        if (hi == NIB_END) begin
          tk[0].token_kind = KIND_REALEND;
          n = 1;
          dec_phase = PH_IDLE;
        end else begin
          tk[0].token_kind = KIND_NIBBLE;
          tk[0].real_nibble = hi;
          if (lo == NIB_END) begin
            tk[1].token_kind = KIND_REALEND;
            dec_phase = PH_IDLE;
          end else begin
            tk[1].token_kind = KIND_NIBBLE;
            tk[1].real_nibble = lo;
          end
          n = 2;
        end
      end
      default: begin
        dec_phase = PH_IDLE;
        if (b == BYTE_ESC) begin
          dec_phase = PH_ESCAPE;
        end else if (b <= LAST_OP) begin
          tk[0].token_kind = KIND_OP;
          tk[0].operator_code = b;
          n = 1;
        end else if (b == BYTE_SHORT || b == BYTE_LONG) begin
          lead = b;
          acc = '0;
          ints_left = (b == BYTE_SHORT) ? 3'd2 : 3'd4;
          dec_phase = PH_INTEGER;
        end else if (b == BYTE_REAL) begin
          dec_phase = PH_REAL;
        end else if (b == BYTE_T2) begin
          tk[0].token_kind = KIND_UNSUP;
          n = 1;
        end else if (b <= LAST_SMALL) begin
          tk[0].token_kind = KIND_INT;
          tk[0].int_value = int'(b) - 139;
          n = 1;
        end else if (b <= LAST_NEG2) begin
          lead = b;
          acc = '0;
          ints_left = 3'd1;
          dec_phase = PH_INTEGER;
        end else begin
          tk[0].token_kind = KIND_RESV;
          n = 1;
        end
      end
    endcase
    if (w.stream_end && dec_phase != PH_IDLE) begin
      tk[0] = BLANK_WORD;
      tk[0].token_kind = KIND_TRUNC;
      n = 1;
      dec_phase = PH_IDLE;
      ints_left = '0;
      acc = '0;
      lead = '0;
    end
    if (n > 0) tk[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(tk[i]);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic e);
    in_word_t w;
    w.dict_byte = b;
    w.stream_end = e;
    pending.push_back(w);
  endtask

  task automatic queue_token();
    logic [7:0] seq [$];
    logic [7:0] b;
    logic [3:0] h;
    logic [3:0] l;
    int         pick;
    int         r;
    int         cut;
    int         n;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b = 8'($urandom);
      queue_byte(b, $urandom_range(0, 7) == 0);
      return;
    end
    if (pick < 22) begin
      b = 8'($urandom_range(0, 26));
      if (b >= BYTE_ESC) b = b + 8'd1;
      seq.push_back(b);
    end else if (pick < 32) begin
      seq.push_back(BYTE_ESC);
      if ($urandom_range(0, 1)) b = 8'($urandom_range(0, 45));
      else b = 8'($urandom);
      seq.push_back(b);
    end else if (pick < 43) begin
      seq.push_back(BYTE_SHORT);
      repeat (2) begin
        b = 8'($urandom);
        seq.push_back(b);
      end
    end else if (pick < 52) begin
      seq.push_back(BYTE_LONG);
      repeat (4) begin
        b = 8'($urandom);
        seq.push_back(b);
      end
    end else if (pick < 68) begin
      b = 8'($urandom_range(FIRST_SMALL, LAST_SMALL));
      seq.push_back(b);
    end else if (pick < 79) begin
      b = 8'($urandom_range(FIRST_POS2, LAST_NEG2));
      seq.push_back(b);
      b = 8'($urandom);
      seq.push_back(b);
    end else if (pick < 93) begin
      seq.push_back(BYTE_REAL);
      n = $urandom_range(0, 4);
      repeat (n) begin
        h = 4'($urandom_range(0, 14));
        l = 4'($urandom_range(0, 14));
        seq.push_back({h, l});
      end
      h = 4'($urandom_range(0, 14));
      l = 4'($urandom);
      if ($urandom_range(0, 1)) seq.push_back({h, NIB_END});
      else seq.push_back({NIB_END, l});
    end else if (pick < 97) begin
      seq.push_back(BYTE_T2);
    end else begin
      seq.push_back(BYTE_RSVD);
    end
    r = $urandom_range(0, 99);
    if (r < 6 && seq.size() > 1) begin
      cut = $urandom_range(0, seq.size() - 2);
      for (int i = 0; i < cut; i++) queue_byte(seq[i], 1'b0);
      queue_byte(seq[cut], 1'b1);
    end else begin
      for (int i = 0; i < seq.size(); i++) queue_byte(seq[i], i == seq.size() - 1 && r >= 92);
    end
  endtask

  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
    out_taken = out_valid_o && !out_stall_i;
    if (in_taken) begin
      decode_dict_byte(in_word_i);
      bytes_in++;
    end
    if (out_taken) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: kind %0d op %0d int %0d nib %0d last %0b",
                   out_word_o.token_kind, out_word_o.operator_code,
                   out_word_o.int_value, out_word_o.real_nibble, out_word_o.last);
      end else begin
        want = expected_tokens.pop_front();
        if (out_word_o.token_kind !== want.token_kind ||
            out_word_o.operator_code !== want.operator_code ||
            out_word_o.int_value !== want.int_value ||
            out_word_o.real_nibble !== want.real_nibble ||
            out_word_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("exp/got kind %0d/%0d op %0d/%0d int %0d/%0d nib %0d/%0d last %0b/%0b",
                     want.token_kind, out_word_o.token_kind,
                     want.operator_code, out_word_o.operator_code,
                     want.int_value, out_word_o.int_value,
                     want.real_nibble, out_word_o.real_nibble,
                     want.last, out_word_o.last);
        end
      end
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) void'(pending.pop_front());
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0) begin
          in_valid_i <= 1'b1;
          in_word_i <= pending[0];
          in_gap = gap_len(calm_stretch());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left == 0 && bytes_in >= next_hold_at) begin
      hold_left = LONG_HOLD;
      next_hold_at += 900;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap = gap_len(calm_stretch());
    end
  end

  initial begin
    queue_byte(8'd0, 1'b0);
    queue_byte(LAST_OP, 1'b0);
    queue_byte(BYTE_ESC, 1'b0);
    queue_byte(LAST_ESCOP, 1'b0);
    queue_byte(BYTE_ESC, 1'b0);
    queue_byte(8'd40, 1'b0);
    queue_byte(BYTE_LONG, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(FIRST_SMALL, 1'b0);
    queue_byte(LAST_SMALL, 1'b0);
    queue_byte(LAST_POS2, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(LAST_NEG2, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(BYTE_RSVD, 1'b0);
    queue_byte(BYTE_T2, 1'b0);
    queue_byte(BYTE_REAL, 1'b0);
    queue_byte(8'hab, 1'b0);
    queue_byte(8'hcd, 1'b0);
    queue_byte(8'hef, 1'b0);
    queue_byte(BYTE_REAL, 1'b0);
    queue_byte(8'hf5, 1'b0);
    queue_byte(BYTE_ESC, 1'b1);
    queue_byte(BYTE_REAL, 1'b0);
    queue_byte(8'h12, 1'b1);
    queue_byte(8'd100, 1'b1);
    while (pending.size() < STREAM_BYTES) queue_token();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i || expected_tokens.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
